FILE: sv/dmpm_pkg.sv
// ----------------------------------------------------------------------------
// dmpm_pkg
// shared constants, types and symbol compare helpers for the mismatch matcher
// ----------------------------------------------------------------------------
package dmpm_pkg;

    localparam int PATTERN_MAX = 64;
    localparam int CELL_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int GROUP_SIZE  = 8;
    localparam int N_GROUPS    = (PATTERN_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_W       = N_GROUPS * GROUP_SIZE;
    localparam int GROUP_CNT_W = $clog2(GROUP_SIZE + 1);

    localparam int ACTION_W   = 2;
    localparam int PIDX_W     = 6;
    localparam int SYM_W      = 8;
    localparam int POS_W      = 32;
    localparam int PLEN_W     = 7;
    localparam int ERR_W      = 6;
    localparam int SMODE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_DIRECT = 2'd0,
        ACT_LOAD_COMP   = 2'd1,
        ACT_SEQUENCE    = 2'd2,
        ACT_RESTART     = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LEN = 3'd0,
        CFG_MAX_ERRORS  = 3'd1,
        CFG_STRAND_MODE = 3'd2,
        CFG_AMBIGUOUS   = 3'd3,
        CFG_SINGLE_SHOT = 3'd4
    } cfg_reg_t;

    localparam logic [SMODE_W-1:0] STRAND_DIRECT = 2'd0;
    localparam logic [SMODE_W-1:0] STRAND_COMP   = 2'd1;
    localparam logic [SMODE_W-1:0] STRAND_BOTH   = 2'd2;

    localparam logic [3:0] BASE_A    = 4'h1;
    localparam logic [3:0] BASE_C    = 4'h2;
    localparam logic [3:0] BASE_G    = 4'h4;
    localparam logic [3:0] BASE_T    = 4'h8;
    localparam logic [3:0] BASE_NONE = 4'h0;

    typedef struct packed {
        logic win_shift;
        logic pat_shift;
        logic wr_dir;
        logic wr_comp;
        logic ambiguous;
        logic active;
    } cell_ctrl_t;

    typedef struct packed {
        logic dir;
        logic comp;
    } mis_t;

    typedef struct packed {
        logic                  win_shift;
        logic [SYM_W-1:0]      win_sym;
        logic                  pat_shift;
        logic [SYM_W-1:0]      pat_dir;
        logic [SYM_W-1:0]      pat_comp;
        logic                  wr_dir;
        logic                  wr_comp;
        logic [CELL_IDX_W-1:0] wr_cell;
        logic [SYM_W-1:0]      wr_sym;
        logic                  ambiguous;
        logic [LEN_W-1:0]      base;
    } row_ctrl_t;

    typedef struct packed {
        logic valid;
        logic dir_ok;
        logic comp_ok;
    } hit_t;

    function automatic logic [3:0] iupac_mask(input logic [SYM_W-1:0] c);
        logic [3:0] m;
        case (c)
            "A":     m = BASE_A;
            "C":     m = BASE_C;
            "G":     m = BASE_G;
            "T":     m = BASE_T;
            "M":     m = BASE_A | BASE_C;
            "R":     m = BASE_A | BASE_G;
            "W":     m = BASE_A | BASE_T;
            "S":     m = BASE_C | BASE_G;
            "Y":     m = BASE_C | BASE_T;
            "K":     m = BASE_G | BASE_T;
            "V":     m = BASE_A | BASE_C | BASE_G;
            "H":     m = BASE_A | BASE_C | BASE_T;
            "D":     m = BASE_A | BASE_G | BASE_T;
            "B":     m = BASE_C | BASE_G | BASE_T;
            "N":     m = BASE_A | BASE_C | BASE_G | BASE_T;
            default: m = BASE_NONE;
        endcase
        return m;
    endfunction

    function automatic logic symbols_agree(input logic [SYM_W-1:0] a,
                                           input logic [SYM_W-1:0] b,
                                           input logic             amb);
        logic r;
        if (amb)
            r = |(iupac_mask(a) & iupac_mask(b));
        else
            r = (a == b);
        return r;
    endfunction

endpackage

FILE: sv/dmpm_cmd_if.sv
// ----------------------------------------------------------------------------
// dmpm_cmd_if
// command channel: pattern loads, sequence symbols and restart
// ----------------------------------------------------------------------------
interface dmpm_cmd_if import dmpm_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PIDX_W-1:0]   pattern_index;
    logic [SYM_W-1:0]    symbol;

    modport source (output valid, action, pattern_index, symbol, input ready);
    modport sink   (input valid, action, pattern_index, symbol, output ready);

endinterface

FILE: sv/dmpm_res_if.sv
// ----------------------------------------------------------------------------
// dmpm_res_if
// result channel: window start, strand and last flag of each match
// ----------------------------------------------------------------------------
interface dmpm_res_if import dmpm_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] match_start;
    logic             strand;
    logic             last;

    modport source (output valid, match_start, strand, last, input ready);
    modport sink   (input valid, match_start, strand, last, output ready);

endinterface

FILE: sv/dmpm_cfg_if.sv
// ----------------------------------------------------------------------------
// dmpm_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface dmpm_cfg_if import dmpm_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

FILE: sv/dmpm_cell.sv
// ----------------------------------------------------------------------------
// dmpm_cell
// one matcher cell: window symbol, both pattern symbols and registered
// mismatch flags; symbols move one cell down the row on each shift
// ----------------------------------------------------------------------------
module dmpm_cell import dmpm_pkg::*; (
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [SYM_W-1:0] win_in,
    input  logic [SYM_W-1:0] dir_in,
    input  logic [SYM_W-1:0] comp_in,
    input  logic [SYM_W-1:0] wr_sym,
    output logic [SYM_W-1:0] win_q,
    output logic [SYM_W-1:0] dir_q,
    output logic [SYM_W-1:0] comp_q,
    output mis_t             mis
);

    logic [SYM_W-1:0] win_reg,  win_next;
    logic [SYM_W-1:0] dir_reg,  dir_next;
    logic [SYM_W-1:0] comp_reg, comp_next;
    mis_t             mis_reg,  mis_next;

    always_comb
    begin
        win_next  = ctrl.win_shift ? win_in : win_reg;
        dir_next  = dir_reg;
        comp_next = comp_reg;
        if (ctrl.pat_shift)
        begin
            dir_next  = dir_in;
            comp_next = comp_in;
        end
        else
        begin
            if (ctrl.wr_dir)
                dir_next = wr_sym;
            if (ctrl.wr_comp)
                comp_next = wr_sym;
        end
        mis_next.dir  = ctrl.active && !symbols_agree(win_reg, dir_reg, ctrl.ambiguous);
        mis_next.comp = ctrl.active && !symbols_agree(win_reg, comp_reg, ctrl.ambiguous);
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        dir_reg  <= dir_next;
        comp_reg <= comp_next;
        mis_reg  <= mis_next;
    end

    assign win_q  = win_reg;
    assign dir_q  = dir_reg;
    assign comp_q = comp_reg;
    assign mis    = mis_reg;

endmodule

FILE: sv/dmpm_cell_row.sv
// ----------------------------------------------------------------------------
// dmpm_cell_row
// row of matcher cells; the newest symbol enters the top cell, so the
// last len cells line up with pattern entries 0 to len-1
// ----------------------------------------------------------------------------
module dmpm_cell_row import dmpm_pkg::*; (
    input  logic                   clk,
    input  row_ctrl_t              ctrl,
    output logic [PATTERN_MAX-1:0] mis_dir,
    output logic [PATTERN_MAX-1:0] mis_comp
);

    logic [SYM_W-1:0] win_q  [PATTERN_MAX];
    logic [SYM_W-1:0] dir_q  [PATTERN_MAX];
    logic [SYM_W-1:0] comp_q [PATTERN_MAX];
    mis_t             mis_w  [PATTERN_MAX];

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        cell_ctrl_t       cc;
        logic [SYM_W-1:0] win_in;
        logic [SYM_W-1:0] dir_in;
        logic [SYM_W-1:0] comp_in;

        always_comb
        begin
            cc.win_shift = ctrl.win_shift;
            cc.pat_shift = ctrl.pat_shift;
            cc.wr_dir    = ctrl.wr_dir  && (ctrl.wr_cell == CELL_IDX_W'(j));
            cc.wr_comp   = ctrl.wr_comp && (ctrl.wr_cell == CELL_IDX_W'(j));
            cc.ambiguous = ctrl.ambiguous;
            cc.active    = (LEN_W'(j) >= ctrl.base);
        end

        if (j == PATTERN_MAX - 1)
        begin : g_head
            assign win_in  = ctrl.win_sym;
            assign dir_in  = ctrl.pat_dir;
            assign comp_in = ctrl.pat_comp;
        end
        else
        begin : g_link
            assign win_in  = win_q[j+1];
            assign dir_in  = dir_q[j+1];
            assign comp_in = comp_q[j+1];
        end

        dmpm_cell u_cell (
            .clk     (clk),
            .ctrl    (cc),
            .win_in  (win_in),
            .dir_in  (dir_in),
            .comp_in (comp_in),
            .wr_sym  (ctrl.wr_sym),
            .win_q   (win_q[j]),
            .dir_q   (dir_q[j]),
            .comp_q  (comp_q[j]),
            .mis     (mis_w[j])
        );

        assign mis_dir[j]  = mis_w[j].dir;
        assign mis_comp[j] = mis_w[j].comp;
    end

endmodule

FILE: sv/dmpm_count.sv
// ----------------------------------------------------------------------------
// dmpm_count
// two-stage registered mismatch count per strand and threshold compare
// ----------------------------------------------------------------------------
module dmpm_count import dmpm_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [PATTERN_MAX-1:0] mis_dir,
    input  logic [PATTERN_MAX-1:0] mis_comp,
    input  logic [ERR_W-1:0]       max_errors,
    output hit_t                   hit
);

    logic [PAD_W-1:0]       pad_dir;
    logic [PAD_W-1:0]       pad_comp;
    logic [GROUP_CNT_W-1:0] grp_dir_reg  [N_GROUPS];
    logic [GROUP_CNT_W-1:0] grp_comp_reg [N_GROUPS];
    logic [GROUP_CNT_W-1:0] grp_dir_next [N_GROUPS];
    logic [GROUP_CNT_W-1:0] grp_comp_next[N_GROUPS];
    logic [LEN_W-1:0]       tot_dir;
    logic [LEN_W-1:0]       tot_comp;
    logic                   valid_a_reg;
    hit_t                   hit_reg, hit_next;

    assign pad_dir  = PAD_W'(mis_dir);
    assign pad_comp = PAD_W'(mis_comp);

    // stage a: popcount of each group of eight cells
    always_comb
    begin
        for (int g = 0; g < N_GROUPS; g++)
        begin
            grp_dir_next[g]  = '0;
            grp_comp_next[g] = '0;
            for (int b = 0; b < GROUP_SIZE; b++)
            begin
                grp_dir_next[g]  = grp_dir_next[g]
                                 + GROUP_CNT_W'(pad_dir[g*GROUP_SIZE + b]);
                grp_comp_next[g] = grp_comp_next[g]
                                 + GROUP_CNT_W'(pad_comp[g*GROUP_SIZE + b]);
            end
        end
    end

    // stage b: sum of groups and compare with allowed errors
    always_comb
    begin
        tot_dir  = '0;
        tot_comp = '0;
        for (int g = 0; g < N_GROUPS; g++)
        begin
            tot_dir  = tot_dir  + LEN_W'(grp_dir_reg[g]);
            tot_comp = tot_comp + LEN_W'(grp_comp_reg[g]);
        end
        hit_next.valid   = valid_a_reg;
        hit_next.dir_ok  = (32'(tot_dir)  <= 32'(max_errors));
        hit_next.comp_ok = (32'(tot_comp) <= 32'(max_errors));
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < N_GROUPS; g++)
        begin
            grp_dir_reg[g]  <= grp_dir_next[g];
            grp_comp_reg[g] <= grp_comp_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            hit_reg     <= '0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            hit_reg     <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

FILE: sv/dna_mismatch_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// dna_mismatch_pattern_matcher_top
// approximate pattern matcher for dna symbols over a row of window cells
// ----------------------------------------------------------------------------
// channels: cmd takes one word per pattern load, sequence symbol or restart;
// result gives one word per matching strand, direct first, last set on the
// final word of a symbol; cfg writes the five registers by index and is
// always ready
// timing: loads, restarts, ignored symbols and symbols that leave the
// window short of the pattern length keep cmd ready; a symbol that
// completes a window has its first result word offered after the cell
// compare stage, the two count stages, the strand-hit capture and the
// hand-off to the output register, which waits for it to drain
// throughput: one item at a time, cmd not ready until the hand-off
// a pattern_len write reloads the cell pattern copies from the pattern
// memories, with cmd held not ready
// reset clears registers, position, fill count and the scan-stopped flag,
// but sets pattern_len to 1; pattern contents are undefined until loaded
// a stalled result keeps its word; the next command is still taken, and
// its results wait until the output register has drained
// ----------------------------------------------------------------------------
module dna_mismatch_pattern_matcher_top import dmpm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    dmpm_cmd_if.sink   cmd,
    dmpm_res_if.source result,
    dmpm_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REBUILD,
        S_BUSY,
        S_EMIT
    } state_t;

    state_t              state_reg,        state_next;
    logic [PLEN_W-1:0]   pattern_len_reg,  pattern_len_next;
    logic [ERR_W-1:0]    max_errors_reg,   max_errors_next;
    logic [SMODE_W-1:0]  strand_mode_reg,  strand_mode_next;
    logic                ambiguous_reg,    ambiguous_next;
    logic                single_shot_reg,  single_shot_next;
    logic [POS_W-1:0]    position_reg,     position_next;
    logic [LEN_W-1:0]    fill_reg,         fill_next;
    logic                finished_reg,     finished_next;
    logic [POS_W-1:0]    start_reg,        start_next;
    logic                eval1_reg,        eval1_next;
    logic                eval2_reg,        eval2_next;
    logic [1:0]          hits_reg,         hits_next;
    logic [1:0]          pending_reg,      pending_next;
    logic [POS_W-1:0]    out_start_reg,    out_start_next;
    logic [LEN_W-1:0]    rb_idx_reg,       rb_idx_next;
    logic                rb_rd_reg,        rb_rd_next;

    logic [SYM_W-1:0]    dir_mem  [PATTERN_MAX];
    logic [SYM_W-1:0]    comp_mem [PATTERN_MAX];
    logic [SYM_W-1:0]    dir_rd_reg;
    logic [SYM_W-1:0]    comp_rd_reg;

    logic                   cmd_fire;
    logic                   cfg_fire;
    logic                   res_fire;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       fill_inc;
    logic                   seq_take;
    logic                   dir_en;
    logic                   comp_en;
    logic                   load_ok;
    logic                   load_in_len;
    logic                   mem_wr_dir;
    logic                   mem_wr_comp;
    logic [CELL_IDX_W-1:0]  mem_wr_addr;
    logic [CELL_IDX_W-1:0]  rb_addr;
    row_ctrl_t              row_ctrl;
    logic [PATTERN_MAX-1:0] mis_dir;
    logic [PATTERN_MAX-1:0] mis_comp;
    hit_t                   hit;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign res_fire = result.valid && result.ready;

    always_comb
    begin
        if (pattern_len_reg == '0)
            len_eff = LEN_W'(1);
        else if (32'(pattern_len_reg) > 32'(PATTERN_MAX))
            len_eff = LEN_W'(PATTERN_MAX);
        else
            len_eff = LEN_W'(pattern_len_reg);
    end

    assign fill_inc = (fill_reg < LEN_W'(PATTERN_MAX)) ? fill_reg + LEN_W'(1) : fill_reg;
    assign seq_take = cmd_fire && (cmd.action == ACT_SEQUENCE) && !finished_reg;
    assign dir_en   = (strand_mode_reg == STRAND_DIRECT) || (strand_mode_reg == STRAND_BOTH);
    assign comp_en  = (strand_mode_reg == STRAND_COMP)   || (strand_mode_reg == STRAND_BOTH);

    assign load_ok     = 32'(cmd.pattern_index) < 32'(PATTERN_MAX);
    assign load_in_len = 32'(cmd.pattern_index) < 32'(len_eff);
    assign mem_wr_dir  = cmd_fire && (cmd.action == ACT_LOAD_DIRECT) && load_ok;
    assign mem_wr_comp = cmd_fire && (cmd.action == ACT_LOAD_COMP)   && load_ok;
    assign mem_wr_addr = CELL_IDX_W'(cmd.pattern_index);
    assign rb_addr     = CELL_IDX_W'(rb_idx_reg);

    // pattern memories, read one entry a cycle while reloading the cells
    always_ff @(posedge clk)
    begin
        if (mem_wr_dir)
            dir_mem[mem_wr_addr] <= cmd.symbol;
        if (mem_wr_comp)
            comp_mem[mem_wr_addr] <= cmd.symbol;
        dir_rd_reg  <= dir_mem[rb_addr];
        comp_rd_reg <= comp_mem[rb_addr];
    end

    always_comb
    begin
        row_ctrl.win_shift = seq_take;
        row_ctrl.win_sym   = cmd.symbol;
        row_ctrl.pat_shift = rb_rd_reg;
        row_ctrl.pat_dir   = dir_rd_reg;
        row_ctrl.pat_comp  = comp_rd_reg;
        row_ctrl.wr_dir    = mem_wr_dir  && load_in_len;
        row_ctrl.wr_comp   = mem_wr_comp && load_in_len;
        row_ctrl.wr_cell   = CELL_IDX_W'(32'(cmd.pattern_index) + 32'(PATTERN_MAX)
                                         - 32'(len_eff));
        row_ctrl.wr_sym    = cmd.symbol;
        row_ctrl.ambiguous = ambiguous_reg;
        row_ctrl.base      = LEN_W'(PATTERN_MAX) - len_eff;
    end

    dmpm_cell_row u_row (
        .clk      (clk),
        .ctrl     (row_ctrl),
        .mis_dir  (mis_dir),
        .mis_comp (mis_comp)
    );

    dmpm_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (eval2_reg),
        .mis_dir    (mis_dir),
        .mis_comp   (mis_comp),
        .max_errors (max_errors_reg),
        .hit        (hit)
    );

    always_comb
    begin
        state_next       = state_reg;
        pattern_len_next = pattern_len_reg;
        max_errors_next  = max_errors_reg;
        strand_mode_next = strand_mode_reg;
        ambiguous_next   = ambiguous_reg;
        single_shot_next = single_shot_reg;
        position_next    = position_reg;
        fill_next        = fill_reg;
        finished_next    = finished_reg;
        start_next       = start_reg;
        eval1_next       = 1'b0;
        eval2_next       = eval1_reg;
        hits_next        = hits_reg;
        pending_next     = pending_reg;
        out_start_next   = out_start_reg;
        rb_idx_next      = rb_idx_reg;
        rb_rd_next       = 1'b0;

        // drop the word just taken, direct before complement
        if (res_fire)
            pending_next = pending_reg[0] ? {pending_reg[1], 1'b0} : 2'b00;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.action)
                        ACT_RESTART:
                        begin
                            position_next = '0;
                            fill_next     = '0;
                            finished_next = 1'b0;
                        end
                        ACT_SEQUENCE:
                        begin
                            if (!finished_reg)
                            begin
                                fill_next     = fill_inc;
                                position_next = position_reg + POS_W'(1);
                                start_next    = position_reg - POS_W'(len_eff) + POS_W'(1);
                                if (fill_inc >= len_eff)
                                begin
                                    eval1_next = 1'b1;
                                    state_next = S_BUSY;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BUSY:
            begin
                if (hit.valid)
                begin
                    hits_next  = {hit.comp_ok && comp_en, hit.dir_ok && dir_en};
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (pending_reg == 2'b00)
                begin
                    pending_next   = hits_reg;
                    out_start_next = start_reg;
                    if ((hits_reg != 2'b00) && single_shot_reg)
                        finished_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REBUILD:
            begin
                if (rb_idx_reg < len_eff)
                begin
                    rb_idx_next = rb_idx_reg + LEN_W'(1);
                    rb_rd_next  = 1'b1;
                end
                else if (!rb_rd_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_fire)
        begin
            case (cfg.index)
                CFG_PATTERN_LEN:
                begin
                    pattern_len_next = cfg.data[PLEN_W-1:0];
                    state_next       = S_REBUILD;
                    rb_idx_next      = '0;
                    rb_rd_next       = 1'b0;
                end
                CFG_MAX_ERRORS:  max_errors_next  = cfg.data[ERR_W-1:0];
                CFG_STRAND_MODE: strand_mode_next = cfg.data[SMODE_W-1:0];
                CFG_AMBIGUOUS:   ambiguous_next   = cfg.data[0];
                CFG_SINGLE_SHOT: single_shot_next = cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pattern_len_reg <= PLEN_W'(1);
            max_errors_reg  <= '0;
            strand_mode_reg <= STRAND_DIRECT;
            ambiguous_reg   <= 1'b0;
            single_shot_reg <= 1'b0;
            position_reg    <= '0;
            fill_reg        <= '0;
            finished_reg    <= 1'b0;
            start_reg       <= '0;
            eval1_reg       <= 1'b0;
            eval2_reg       <= 1'b0;
            hits_reg        <= 2'b00;
            pending_reg     <= 2'b00;
            out_start_reg   <= '0;
            rb_idx_reg      <= '0;
            rb_rd_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pattern_len_reg <= pattern_len_next;
            max_errors_reg  <= max_errors_next;
            strand_mode_reg <= strand_mode_next;
            ambiguous_reg   <= ambiguous_next;
            single_shot_reg <= single_shot_next;
            position_reg    <= position_next;
            fill_reg        <= fill_next;
            finished_reg    <= finished_next;
            start_reg       <= start_next;
            eval1_reg       <= eval1_next;
            eval2_reg       <= eval2_next;
            hits_reg        <= hits_next;
            pending_reg     <= pending_next;
            out_start_reg   <= out_start_next;
            rb_idx_reg      <= rb_idx_next;
            rb_rd_reg       <= rb_rd_next;
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign result.valid       = |pending_reg;
    assign result.match_start = out_start_reg;
    assign result.strand      = !pending_reg[0];
    assign result.last        = (pending_reg != 2'b11);

    a_hit_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        hit.valid |-> (state_reg == S_BUSY))
        else $error("count result outside busy state");

    a_stopped_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && cmd_fire && (cmd.action == ACT_SEQUENCE)) |=> $stable(position_reg))
        else $error("position moved after single-shot stop");

    a_emit_loads_hits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && (pending_reg == 2'b00))
        |=> (result.valid == ($past(hits_reg) != 2'b00)))
        else $error("result word does not follow strand hits");

endmodule
